// ----- hdl/slne_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slne_pkg
// Shared types, codes and key ordering for the sorted leaf node engine.
// ----------------------------------------------------------------------------
package slne_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned CNT_W           = 7;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 7;
  localparam logic [CNT_W-1:0] MIN_ENTRIES_RST = 7'd32;

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_DELETED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_SPLIT     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_IS_REAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ENTRIES = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] rid_page;
    logic [15:0] rid_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
    logic             underflow;
    logic [31:0]      out_key;
    logic [31:0]      out_rid_page;
    logic [15:0]      out_rid_slot;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] page;
    logic [15:0] slot;
  } entry_t;

  // what a cell does with its entry at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_t;

  // probe broadcast to every cell when a transaction is accepted
  typedef struct packed {
    logic             en;
    logic             is_del;
    logic             key_is_real;
    logic [CNT_W-1:0] count;
    entry_t           probe;
  } cell_cmp_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] real_order(input logic [31:0] x);
    return x[31] ? ~x : {1'b1, x[30:0]};
  endfunction

  // a sorts strictly below b
  function automatic logic key_less(input logic real_mode, input logic [31:0] a,
                                    input logic [31:0] b);
    logic res;
    if (real_mode) begin
      if (is_nan(a) || is_nan(b)) begin
        res = 1'b0;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
        res = 1'b0;
      end else begin
        res = real_order(a) < real_order(b);
      end
    end else begin
      res = {~a[31], a[30:0]} < {~b[31], b[30:0]};
    end
    return res;
  endfunction

endpackage : slne_pkg
`default_nettype wire

// ----- hdl/slne_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slne_cell
// One slot of the leaf: holds an entry, compares it against the probe and
// takes a new entry from the input or from either neighbor.
// ----------------------------------------------------------------------------
module slne_cell
  import slne_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic      clk,
  input  wire cell_cmp_t cmp,
  input  wire cell_op_t  op,
  input  wire entry_t    load_entry,
  input  wire entry_t    prev_entry,
  input  wire entry_t    next_entry,
  output entry_t         entry,
  output logic           flag
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   flag_r;
  logic   flag_nxt;
  logic   occupied;

  assign occupied = MY_IDX < cmp.count;

  always_comb begin
    // delete: exact match; insert: new key sorts below this one, or first free slot
    if (cmp.is_del) begin
      flag_nxt = occupied && (entry_r == cmp.probe);
    end else begin
      flag_nxt = (occupied && key_less(cmp.key_is_real, cmp.probe.key, entry_r.key)) ||
                 (MY_IDX == cmp.count);
    end
  end

  always_comb begin
    case (op)
      CELL_LOAD:      entry_nxt = load_entry;
      CELL_FROM_PREV: entry_nxt = prev_entry;
      CELL_FROM_NEXT: entry_nxt = next_entry;
      default:        entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (cmp.en) begin
      flag_r <= flag_nxt;
    end
  end

  assign entry = entry_r;
  assign flag  = flag_r;

endmodule : slne_cell
`default_nettype wire

// ----- hdl/sorted_leaf_node_engine_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_leaf_node_engine_unit
// One B+ tree leaf held as a chain of CAPACITY+1 cells kept in key order.
// ----------------------------------------------------------------------------
// Input transactions (insert or delete) arrive on in_valid/in_stall, results
// leave on out_valid/out_stall through a one-deep output register.
// An accepted transaction is compared against every cell in the accept cycle;
// in the apply state, once the output register is free, a prefix of the
// registered per-cell flags picks the position, the chain shifts up or down by
// one and a delete or non-full insert result enters the output register.
// in_stall stays high until the block is idle again. The extra top cell holds
// the overflow entry of an insert into a full leaf: the lower (CAPACITY+1)/2
// entries stay and the upper CAPACITY+1-(CAPACITY+1)/2 drain from the split
// boundary, one result per cycle unless stalled, with last on the final one.
// When out_stall holds a waiting result, the block still takes one new
// transaction but does not update the chain until the output register frees.
// Reset (rst_n low, synchronous) empties the leaf and restores key_is_real 0
// and min_entries 32; cell contents are not cleared, no clearing pass runs.
// Write configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
module sorted_leaf_node_engine_unit
  import slne_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned NCELL   = CAPACITY + 1;
  localparam int unsigned KEEP    = NCELL / 2;
  localparam int unsigned DRAIN_N = NCELL - KEEP;
  localparam int unsigned REM_W   = $clog2(DRAIN_N + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_DRAIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [REM_W-1:0] remain_r, remain_nxt;
  logic             key_is_real_r;
  logic [CNT_W-1:0] min_entries_r;
  in_item_t         item_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  entry_t    cell_q [NCELL];
  cell_op_t  cell_op [NCELL];
  logic [NCELL-1:0] flags;
  logic [NCELL-1:0] pfx;
  cell_cmp_t cmp;
  entry_t    load_entry;
  entry_t    zero_entry;
  logic      accept;
  logic      out_free;
  logic      full;
  logic      found;
  logic [CNT_W-1:0] count_dec;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign zero_entry = '0;
  assign load_entry = '{key: item_r.key, page: item_r.rid_page, slot: item_r.rid_slot};

  assign cmp.en          = accept;
  assign cmp.is_del      = (in_data.func == FUNC_DELETE);
  assign cmp.key_is_real = key_is_real_r;
  assign cmp.count       = count_r;
  assign cmp.probe       = '{key: in_data.key, page: in_data.rid_page,
                             slot: in_data.rid_slot};

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign found     = pfx[NCELL-1];
  assign count_dec = count_r - 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      // position at or after the first flagged cell
      assign pfx[gi] = |(flags & ({NCELL{1'b1}} >> (NCELL - 1 - gi)));

      slne_cell #(
        .IDX (gi)
      ) u_cell (
        .clk        (clk),
        .cmp        (cmp),
        .op         (cell_op[gi]),
        .load_entry (load_entry),
        .prev_entry ((gi == 0) ? zero_entry : cell_q[(gi == 0) ? 0 : gi - 1]),
        .next_entry ((gi == NCELL - 1) ? zero_entry :
                     cell_q[(gi == NCELL - 1) ? gi : gi + 1]),
        .entry      (cell_q[gi]),
        .flag       (flags[gi])
      );

      always_comb begin
        cell_op[gi] = CELL_HOLD;
        if ((state_r == S_APPLY) && out_free) begin
          if (item_r.func == FUNC_DELETE) begin
            if (pfx[gi]) begin
              cell_op[gi] = CELL_FROM_NEXT;
            end
          end else if ((gi != 0) && pfx[(gi == 0) ? 0 : gi - 1]) begin
            cell_op[gi] = CELL_FROM_PREV;
          end else if (pfx[gi]) begin
            cell_op[gi] = CELL_LOAD;
          end
        end else if ((state_r == S_DRAIN) && out_free && (gi >= KEEP)) begin
          cell_op[gi] = CELL_FROM_NEXT;
        end
      end
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          out_data_nxt = '0;
          out_data_nxt.last = 1'b1;
          if (item_r.func == FUNC_DELETE) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (found) begin
              count_nxt                = count_dec;
              out_data_nxt.status      = ST_DELETED;
              out_data_nxt.entry_count = count_dec;
              out_data_nxt.underflow   = count_dec < min_entries_r;
            end else begin
              out_data_nxt.status      = ST_NOT_FOUND;
              out_data_nxt.entry_count = count_r;
            end
          end else if (full) begin
            count_nxt  = CNT_W'(KEEP);
            remain_nxt = REM_W'(DRAIN_N);
            state_nxt  = S_DRAIN;
          end else begin
            out_valid_nxt            = 1'b1;
            state_nxt                = S_IDLE;
            count_nxt                = count_r + 1'b1;
            out_data_nxt.status      = ST_INSERTED;
            out_data_nxt.entry_count = count_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = ST_SPLIT;
          out_data_nxt.entry_count  = count_r;
          out_data_nxt.underflow    = 1'b0;
          out_data_nxt.out_key      = cell_q[KEEP].key;
          out_data_nxt.out_rid_page = cell_q[KEEP].page;
          out_data_nxt.out_rid_slot = cell_q[KEEP].slot;
          out_data_nxt.last         = (remain_r == REM_W'(1));
          remain_nxt                = remain_r - 1'b1;
          if (remain_r == REM_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      remain_r      <= '0;
      out_valid_r   <= 1'b0;
      key_is_real_r <= 1'b0;
      min_entries_r <= MIN_ENTRIES_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_IS_REAL: key_is_real_r <= cfg_data[0];
          REG_MIN_ENTRIES: min_entries_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      item_r <= in_data;
    end
  end

endmodule : sorted_leaf_node_engine_unit
`default_nettype wire

// ----- hdl/slne_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slne_checker
// Port-level checks for the sorted leaf node engine, bound to the top level.
// ----------------------------------------------------------------------------
module slne_checker
  import slne_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a waiting result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // each accepted transaction holds the input stalled after the accept
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in back-to-back cycles");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // only a split yields more than one result
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_SPLIT) |-> out_data.last)
    else $error("non-split result without last");

  a_underflow_del: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.underflow |-> out_data.status == ST_DELETED)
    else $error("underflow on a non-delete result");

endmodule : slne_checker

bind sorted_leaf_node_engine_unit slne_checker #(
  .CAPACITY (CAPACITY)
) u_slne_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
